// ===== rtl/pcar_pkg.sv =====
package pcar_pkg;

    // Field widths
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned ALIGN_W    = 4;
    localparam int unsigned AGE_W      = 32;
    localparam int unsigned SLOT_OUT_W = 8;

    // Buffer alignment in bytes; offsets fold modulo this value
    localparam int unsigned ALIGN_BYTES = 16;

    // Saturation value of an age counter
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // Configuration port
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = '0;
    localparam logic [LEN_W-1:0]     THRESHOLD_RESET = 32'd16384;

    // One table entry as held in the memory
    typedef struct packed {
        logic               valid;
        logic [ALIGN_W-1:0] align;
        logic [LEN_W-1:0]   length;
        logic [AGE_W-1:0]   age;
    } t_entry;

    // Control from the sequencer to the search unit
    typedef struct packed {
        logic clr;
        logic vld;
    } t_scan_ctl;

endpackage

// ===== rtl/pcar_apb.sv =====
module pcar_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcar_pkg::PADDR_W-1:0]   paddr,
    input  logic [pcar_pkg::PDATA_W-1:0]   pwdata,
    output logic [pcar_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output logic [pcar_pkg::LEN_W-1:0]     o_threshold
);
    import pcar_pkg::*;

    logic [LEN_W-1:0]     r_threshold;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_stb;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_stb  = psel && penable && pwrite && pready;

    // Write the threshold; other indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (wr_stb && (reg_idx == REG_THRESHOLD)) begin
            r_threshold <= pwdata[LEN_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_THRESHOLD) begin
            prdata = PDATA_W'(r_threshold);
        end
    end

    assign o_threshold = r_threshold;

endmodule

// ===== rtl/pcar_ram.sv =====
module pcar_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned DW    = 69
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);
    logic [DW-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/pcar_scan.sv =====
module pcar_scan #(
    parameter int unsigned SLOT_W = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pcar_pkg::t_scan_ctl             i_ctl,
    input  pcar_pkg::t_entry                i_entry,
    input  logic [SLOT_W-1:0]               i_idx,
    input  logic [pcar_pkg::LEN_W-1:0]      i_key_len,
    input  logic [pcar_pkg::ALIGN_W-1:0]    i_key_align,
    output logic                            o_hit,
    output logic [SLOT_W-1:0]               o_hit_idx,
    output logic [SLOT_W-1:0]               o_victim_idx
);
    import pcar_pkg::*;

    logic              r_hit;
    logic              r_have;
    logic [SLOT_W-1:0] r_hit_idx;
    logic [SLOT_W-1:0] r_best_idx;
    logic [AGE_W-1:0]  r_best_age;
    logic              match;
    logic              better;

    // Key match on a valid entry
    assign match = i_entry.valid && (i_entry.length == i_key_len)
                   && (i_entry.align == i_key_align);

    // Oldest wins; on equal age entry 0 first, then the higher index
    assign better = !r_have
                    || (i_entry.age > r_best_age)
                    || ((i_entry.age == r_best_age) && (r_best_idx != '0)
                        && ((i_idx == '0) || (i_idx > r_best_idx)));

    // Track first hit and the victim candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_have <= 1'b0;
        end else if (i_ctl.clr) begin
            r_hit  <= 1'b0;
            r_have <= 1'b0;
        end else if (i_ctl.vld) begin
            if (match) begin
                r_hit <= 1'b1;
            end
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            if (match && !r_hit) begin
                r_hit_idx <= i_idx;
            end
            if (better) begin
                r_best_idx <= i_idx;
                r_best_age <= i_entry.age;
            end
        end
    end

    assign o_hit        = r_hit;
    assign o_hit_idx    = r_hit_idx;
    assign o_victim_idx = r_best_idx;

endmodule

// ===== rtl/plan_cache_age_replacement_top.sv =====
// Plan cache slot selector. Each item names a transform by length and buffer
// alignment; the block finds the table slot holding that key, or installs it
// over the entry with the greatest age, and returns the slot, a hit flag, the
// quick-plan flag (misses only, length above the threshold register) and the
// direction. Entries live in one memory with a single read and a single
// write port, so each item costs one read pass over all entries for the key
// and oldest search and one read-modify-write pass for the ages. One item
// is worked at a time; a finished result waits in an output register while
// the next item is taken. After reset a clearing pass zeroes the memory
// before the first item is accepted; configuration writes are taken
// throughout. Write the threshold only while no item is in flight.
module plan_cache_age_replacement_top #(
    parameter int unsigned ENTRIES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [pcar_pkg::LEN_W-1:0]          i_transform_length,
    input  logic [pcar_pkg::ALIGN_W-1:0]        i_align_offset,
    input  logic                                i_inverse_direction,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pcar_pkg::SLOT_OUT_W-1:0]     o_slot_index,
    output logic                                o_was_hit,
    output logic                                o_quick_plan,
    output logic                                o_use_inverse,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcar_pkg::PADDR_W-1:0]        paddr,
    input  logic [pcar_pkg::PDATA_W-1:0]        pwdata,
    output logic [pcar_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import pcar_pkg::*;

    localparam int unsigned AW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned EW = $bits(t_entry);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_addr;
    logic [CW-1:0]       r_cnt;
    logic                r_dv;
    logic [AW-1:0]       r_didx;
    logic [AW-1:0]       r_last_slot;
    logic [LEN_W-1:0]    r_len;
    logic [ALIGN_W-1:0]  r_align;
    logic                r_inv;
    logic [AW-1:0]       r_slot;
    logic                r_hit;
    logic                r_quick;
    logic                r_o_valid;
    logic [SLOT_OUT_W-1:0] r_o_slot;
    logic                r_o_hit;
    logic                r_o_quick;
    logic                r_o_inv;

    logic [AW-1:0]       n_addr;
    logic                issue;
    logic                pass_end;
    logic                in_acc;
    logic                out_load;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [EW-1:0]       mem_wd;
    logic [EW-1:0]       mem_rd;
    t_entry              rd_entry;
    t_entry              upd_entry;
    t_scan_ctl           scan_ctl;
    logic                scan_hit;
    logic [AW-1:0]       scan_hit_idx;
    logic [AW-1:0]       scan_victim;
    logic [LEN_W-1:0]    threshold;
    logic [31:0]         slot_ext;
    logic [ALIGN_W-1:0]  align_fold [2**ALIGN_W];

    // Fold the offset modulo the alignment
    for (genvar g = 0; g < 2**ALIGN_W; g++) begin : g_fold
        localparam int unsigned FOLD = g % ALIGN_BYTES;
        assign align_fold[g] = ALIGN_W'(FOLD);
    end

    pcar_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (threshold)
    );

    // Handshakes
    assign o_ready  = (r_state == ST_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_load = (r_state == ST_DONE) && (!r_o_valid || i_ready);

    // Pass control: issue one read per cycle until every entry is read
    assign issue    = ((r_state == ST_SCAN) || (r_state == ST_UPDATE))
                      && (r_cnt != CW'(ENTRIES));
    assign pass_end = (r_cnt == CW'(ENTRIES)) && !r_dv;
    assign n_addr   = (r_addr == AW'(ENTRIES - 1)) ? '0 : r_addr + 1'b1;

    // Age update of the entry just read; install the key on a miss
    assign rd_entry = t_entry'(mem_rd);
    always_comb begin
        upd_entry = rd_entry;
        if (r_didx == r_slot) begin
            upd_entry.age = '0;
            if (!r_hit) begin
                upd_entry.valid  = 1'b1;
                upd_entry.align  = r_align;
                upd_entry.length = r_len;
            end
        end else if (rd_entry.age != AGE_MAX) begin
            upd_entry.age = rd_entry.age + 1'b1;
        end
    end

    // Write port: clearing pass or write-back
    assign mem_we = ((r_state == ST_CLEAR) && (r_cnt != CW'(ENTRIES)))
                    || ((r_state == ST_UPDATE) && r_dv);
    assign mem_wa = (r_state == ST_CLEAR) ? r_addr : r_didx;
    assign mem_wd = (r_state == ST_CLEAR) ? '0 : EW'(upd_entry);

    pcar_ram #(
        .DEPTH (ENTRIES),
        .AW    (AW),
        .DW    (EW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (issue),
        .i_rd_addr (r_addr),
        .i_we      (mem_we),
        .i_wr_addr (mem_wa),
        .i_wr_data (mem_wd),
        .o_rd_data (mem_rd)
    );

    assign scan_ctl.clr = in_acc;
    assign scan_ctl.vld = (r_state == ST_SCAN) && r_dv;

    pcar_scan #(
        .SLOT_W (AW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_entry      (rd_entry),
        .i_idx        (r_didx),
        .i_key_len    (r_len),
        .i_key_align  (r_align),
        .o_hit        (scan_hit),
        .o_hit_idx    (scan_hit_idx),
        .o_victim_idx (scan_victim)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_last_slot <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_dv <= issue;
            // Load the result register, or drop the item once taken
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    if (r_cnt == CW'(ENTRIES)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_addr <= n_addr;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                        r_addr  <= r_last_slot;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_addr <= n_addr;
                    end else if (pass_end) begin
                        r_state <= ST_UPDATE;
                        r_cnt   <= '0;
                        r_addr  <= '0;
                    end
                end
                ST_UPDATE: begin
                    if (issue) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_addr <= n_addr;
                    end else if (pass_end) begin
                        r_last_slot <= r_slot;
                        r_state     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload: request key, decision, result
    assign slot_ext = 32'(r_slot);
    always_ff @(posedge i_clk) begin
        r_didx <= r_addr;
        if (in_acc) begin
            r_len   <= i_transform_length;
            r_align <= align_fold[i_align_offset];
            r_inv   <= i_inverse_direction;
        end
        if ((r_state == ST_SCAN) && pass_end) begin
            r_slot  <= scan_hit ? scan_hit_idx : scan_victim;
            r_hit   <= scan_hit;
            r_quick <= !scan_hit && (r_len > threshold);
        end
        if (out_load) begin
            r_o_slot  <= slot_ext[SLOT_OUT_W-1:0];
            r_o_hit   <= r_hit;
            r_o_quick <= r_quick;
            r_o_inv   <= r_inv;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_slot_index  = r_o_slot;
    assign o_was_hit     = r_o_hit;
    assign o_quick_plan  = r_o_quick;
    assign o_use_inverse = r_o_inv;

    // Write-back never lands on the entry being read
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && issue) |-> (mem_wa != r_addr))
        else $error("memory read and write hit the same entry");

    // The search pass leaves the memory untouched
    a_scan_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !mem_we)
        else $error("memory written during search pass");

    // Last used slot stays inside the table
    a_last_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_slot <= AW'(ENTRIES - 1))
        else $error("last slot beyond table");

    // A hit never carries the quick-plan flag
    a_hit_no_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_hit) |-> !o_quick_plan)
        else $error("quick plan flagged on a hit");

    // A finished update pass moves straight on to the done state
    a_pass_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_UPDATE) && pass_end) |=> (r_state == ST_DONE))
        else $error("update pass did not complete");

endmodule
